### sv/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, character codes and the alphabet decode for the base64
// stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Character codes
  localparam logic [7:0] PadChar     = 8'h3D;
  localparam logic [7:0] NewlineChar = 8'h0A;
  localparam logic [7:0] PlusChar    = 8'h2B;
  localparam logic [7:0] SlashChar   = 8'h2F;

  // Default depth of the command queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // Number of bytes a command carries (full quad, one pad, two pads)
  localparam logic [1:0] BytesFull    = 2'd3;
  localparam logic [1:0] BytesOnePad  = 2'd2;
  localparam logic [1:0] BytesTwoPad  = 2'd1;

  // Character class
  typedef enum logic [1:0] {
    SymData    = 2'd0,
    SymPad     = 2'd1,
    SymNewline = 2'd2,
    SymInvalid = 2'd3
  } b64d_kind_e;

  typedef struct packed {
    b64d_kind_e kind;
    logic [5:0] value;
  } b64d_sym_t;

  // Command from the front part to the back part
  typedef struct packed {
    logic [23:0] group;  // decoded bits, first byte in the high bits
    logic [1:0]  count;  // bytes to emit (1 to 3), unused on error
    logic        last;   // final character flag of the closing request
    logic        err;    // emit one error result
  } b64d_cmd_t;

  // Map one ASCII character to its 6-bit symbol and class
  function automatic b64d_sym_t decode_char(logic [7:0] c);
    b64d_sym_t sym;
    sym.kind  = SymInvalid;
    sym.value = 6'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      sym.kind  = SymData;
      sym.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      sym.kind  = SymData;
      sym.value = 6'(c - 8'h47);
    end else if (c inside {[8'h30:8'h39]}) begin
      sym.kind  = SymData;
      sym.value = 6'(c + 8'h04);
    end else if (c == PlusChar) begin
      sym.kind  = SymData;
      sym.value = 6'd62;
    end else if (c == SlashChar) begin
      sym.kind  = SymData;
      sym.value = 6'd63;
    end else if (c == PadChar) begin
      sym.kind = SymPad;
    end else if (c == NewlineChar) begin
      sym.kind = SymNewline;
    end
    return sym;
  endfunction

endpackage

### sv/base64_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder: one text character in per request, decoded
// bytes or an error result out.
//
//   channel  | dir | tdata          | tlast      | tuser
//   ---------+-----+----------------+------------+----------
//   s_axis   | in  | text_char[7:0] | final_char | -
//   m_axis   | out | data_byte[7:0] | last_byte  | bad_input
//
// The input takes one character per clock while the command queue has room.
// The back end emits one output request per clock unless the output stalls: up
// to three per four-character quad, one per bad character, so it keeps up with
// full rate. A quad's command passes a queue slot and cmd_q before its first
// byte can be taken. Reset clears the quad state, the queue and the output. An
// output stall fills the queue and then drops s_axis_tready.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core #(
  parameter int unsigned QueueDepth = b64d_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_char
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] bad_input
);

  logic                q_full, q_valid, push, pop;
  b64d_pkg::b64d_cmd_t push_cmd, pop_cmd;

  // Classify and gather
  b64d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .in_final_i (s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Decouple front and back
  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  // Emit bytes
  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_bad_o   (m_axis_tuser)
  );

endmodule

### sv/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them and gathers symbols into quads. Issues
// one command per closed quad or per error into the command queue.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_char_i,
  input  logic                in_final_i,
  input  logic                q_full_i,
  output logic                push_o,
  output b64d_pkg::b64d_cmd_t cmd_o
);

  logic [1:0]          pos_q, pos_d;
  logic [17:0]         group_q, group_d;
  logic                pad_seen_q, pad_seen_d;
  b64d_pkg::b64d_sym_t sym;
  logic                accept;
  logic                is_err;
  logic [5:0]          sym_bits;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign sym        = b64d_pkg::decode_char(in_char_i);
  assign sym_bits   = (sym.kind == b64d_pkg::SymPad) ? 6'd0 : sym.value;

  // Flag any misplaced character in the current position
  always_comb begin
    is_err = 1'b0;
    if (sym.kind == b64d_pkg::SymInvalid || sym.kind == b64d_pkg::SymNewline) begin
      is_err = 1'b1;
    end else if (sym.kind == b64d_pkg::SymPad && pos_q < 2'd2) begin
      is_err = 1'b1;
    end else if (pad_seen_q && sym.kind != b64d_pkg::SymPad) begin
      is_err = 1'b1;
    end else if (pos_q != 2'd3 && in_final_i) begin
      is_err = 1'b1;
    end else if (pos_q == 2'd3 && sym.kind == b64d_pkg::SymPad && !in_final_i) begin
      is_err = 1'b1;
    end
  end

  // Advance the quad and build the command
  always_comb begin
    pos_d      = pos_q;
    group_d    = group_q;
    pad_seen_d = pad_seen_q;
    push_o     = 1'b0;
    cmd_o.group = {group_q, sym_bits};
    cmd_o.count = b64d_pkg::BytesFull;
    cmd_o.last  = in_final_i;
    cmd_o.err   = 1'b0;
    if (accept) begin
      if (sym.kind == b64d_pkg::SymNewline && pos_q == 2'd0) begin
        // skip a newline at a quad boundary
      end else if (is_err) begin
        push_o      = 1'b1;
        cmd_o.err   = 1'b1;
        cmd_o.group = 24'd0;
        pos_d       = 2'd0;
        group_d     = 18'd0;
        pad_seen_d  = 1'b0;
      end else if (pos_q != 2'd3) begin
        group_d = {group_q[11:0], sym_bits};
        pos_d   = pos_q + 2'd1;
        if (sym.kind == b64d_pkg::SymPad) begin
          pad_seen_d = 1'b1;
        end
      end else begin
        push_o = 1'b1;
        if (sym.kind == b64d_pkg::SymPad) begin
          cmd_o.count = pad_seen_q ? b64d_pkg::BytesTwoPad : b64d_pkg::BytesOnePad;
        end
        pos_d      = 2'd0;
        group_d    = 18'd0;
        pad_seen_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 2'd0;
      group_q    <= 18'd0;
      pad_seen_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      group_q    <= group_d;
      pad_seen_q <= pad_seen_d;
    end
  end

endmodule

### sv/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short command queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module b64d_queue #(
  parameter int unsigned Depth = b64d_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64d_pkg::b64d_cmd_t push_cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output b64d_pkg::b64d_cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64d_pkg::b64d_cmd_t  slot_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 do_push, do_pop;

  assign full_o    = (cnt_q == FullCnt);
  assign valid_o   = (cnt_q != '0);
  assign pop_cmd_o = slot_q[rd_ptr_q];
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & valid_o;

  // Store the request in the free slot
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### sv/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Takes commands from the queue and emits their bytes one per request,
// first byte of the group first.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  b64d_pkg::b64d_cmd_t q_cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  output logic                out_bad_o
);

  logic                busy_q;
  b64d_pkg::b64d_cmd_t cmd_q;
  logic [1:0]          idx_q;
  logic                final_byte;
  logic                done;

  assign final_byte = cmd_q.err | (idx_q == cmd_q.count - 2'd1);
  assign done       = busy_q & out_ready_i & final_byte;
  assign pop_o      = q_valid_i & (~busy_q | done);

  // Select the current byte of the group
  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = cmd_q.group[23:16];
      2'd1:    out_byte_o = cmd_q.group[15:8];
      2'd2:    out_byte_o = cmd_q.group[7:0];
      default: out_byte_o = 8'd0;
    endcase
  end

  assign out_valid_o = busy_q;
  assign out_last_o  = final_byte & cmd_q.last;
  assign out_bad_o   = cmd_q.err;

  // Hold the command until its bytes are taken
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= 2'd0;
      end else if (done) begin
        busy_q <= 1'b0;
        idx_q  <= 2'd0;
      end else if (busy_q && out_ready_i) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

### sv/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks for the base64 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // Error results carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0)
    else $error("error result with nonzero data");

  // Hold a stalled output request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("stalled output changed");

  // Input side is open right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> s_axis_tready)
    else $error("not ready after reset");

  // No output right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (.*);
